/* design/srt_pkg.sv */
package srt_pkg;

    // item kinds
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    // result codes
    localparam logic [2:0] ST_IN_SECTION  = 3'd0;
    localparam logic [2:0] ST_BELOW_FIRST = 3'd1;
    localparam logic [2:0] ST_PASSTHROUGH = 3'd2;
    localparam logic [2:0] ST_INVALID     = 3'd3;
    localparam logic [2:0] ST_DUPLICATE   = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd5;

    // code and execute characteristics bits
    localparam logic [31:0] EXEC_MASK = 32'h2000_0020;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] start;
        logic [31:0] raw;
        logic        exec;
        logic [31:0] addr;
        logic        en;
    } t_cmd;

endpackage

/* design/section_rva_translation.sv */
// a word passes the front, the command queue, the back table scan and the result register;
//   lookups and adds scan every stored section (at most MAX_SECTIONS), a clear does not scan
// the table scan reads one entry per cycle; the front takes a new word only after pushing the last,
//   with an extra step for an add (page-rounded end key)
// front and back overlap through a two-word command queue
// reset: synchronous active-low clears the section count, the queue and all handshakes;
//   table contents stay undefined and need no clearing pass
module section_rva_translation #(
    parameter int MAX_SECTIONS = 64,
    parameter int PAGE_BYTES   = 4096    // power of two
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_section_start,
    input  logic [31:0] i_section_length,
    input  logic [31:0] i_section_raw_base,
    input  logic [31:0] i_section_flags,
    input  logic [31:0] i_lookup_address,
    input  logic        i_translate_enable,
    // result word channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_translated,
    output logic [2:0]  o_status,
    output logic        o_executable
);
    import srt_pkg::*;

    // front to queue
    logic push;
    t_cmd front_cmd;
    logic q_full;

    // queue to back
    logic pop;
    t_cmd back_cmd;
    logic q_empty;

    // front: takes words, works out the page-rounded end key for adds
    srt_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_section_start    (i_section_start),
        .i_section_length   (i_section_length),
        .i_section_raw_base (i_section_raw_base),
        .i_section_flags    (i_section_flags),
        .i_lookup_address   (i_lookup_address),
        .i_translate_enable (i_translate_enable),
        .o_push             (push),
        .o_cmd              (front_cmd),
        .i_full             (q_full)
    );

    // short command queue so front and back stall independently
    srt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (back_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: owns the section table, scans it and drives the result register
    srt_back #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .i_cmd        (back_cmd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_translated (o_translated),
        .o_status     (o_status),
        .o_executable (o_executable)
    );

endmodule

/* design/srt_queue.sv */
module srt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srt_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output srt_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import srt_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    assign o_cmd   = r_slot[r_rd_ptr];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* design/srt_front.sv */
module srt_front #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_mode,
    input  logic [31:0]   i_section_start,
    input  logic [31:0]   i_section_length,
    input  logic [31:0]   i_section_raw_base,
    input  logic [31:0]   i_section_flags,
    input  logic [31:0]   i_lookup_address,
    input  logic          i_translate_enable,
    output logic          o_push,
    output srt_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import srt_pkg::*;

    localparam int         RW     = $clog2(PAGE_BYTES);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_KEY  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]    r_state;
    t_cmd          r_cmd;
    logic [31:0]   r_length;

    logic [31:0]   adj;
    logic          accept;

    assign o_ready = (r_state == F_IDLE);
    assign accept  = i_valid && o_ready;
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_cmd   = r_cmd;

    // round up to the next page: the low length bits are the remainder
    always_comb begin
        adj = (r_length[RW-1:0] == '0) ? 32'd0
                                       : (32'(PAGE_BYTES) - 32'(r_length[RW-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= (i_mode == MODE_ADD) ? F_KEY : F_PUSH;
                    end
                end
                F_KEY: begin
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.mode  <= i_mode;
            r_cmd.key   <= 32'd0;
            r_cmd.start <= i_section_start;
            r_cmd.raw   <= i_section_raw_base;
            r_cmd.exec  <= |(i_section_flags & EXEC_MASK);
            r_cmd.addr  <= i_lookup_address;
            r_cmd.en    <= i_translate_enable;
            r_length    <= i_section_length;
        end else if (r_state == F_KEY) begin
            // end key wraps modulo 2^32
            r_cmd.key <= r_cmd.start + r_length + adj;
        end
    end

endmodule

/* design/srt_back.sv */
module srt_back #(
    parameter int MAX_SECTIONS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    output logic          o_pop,
    input  srt_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_translated,
    output logic [2:0]    o_status,
    output logic          o_executable
);
    import srt_pkg::*;

    localparam int CW = $clog2(MAX_SECTIONS + 1);
    localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // section table
    logic [31:0] mem_key   [MAX_SECTIONS];
    logic [31:0] mem_start [MAX_SECTIONS];
    logic [31:0] mem_raw   [MAX_SECTIONS];
    logic        mem_exec  [MAX_SECTIONS];

    logic [1:0]  r_state;
    t_cmd        r_cmd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_idx;
    logic        r_rd_vld;
    logic [31:0] r_rd_key;
    logic [31:0] r_rd_start;
    logic [31:0] r_rd_raw;
    logic        r_rd_exec;

    logic        r_found;
    logic [31:0] r_best_key;
    logic [31:0] r_best_start;
    logic [31:0] r_best_raw;
    logic        r_best_exec;
    logic        r_low_valid;
    logic [31:0] r_low_key;
    logic [31:0] r_low_start;
    logic        r_dup;

    logic        r_o_valid;
    logic [31:0] r_o_translated;
    logic [2:0]  r_o_status;
    logic        r_o_exec;

    logic        issue;
    logic        better;
    logic        lower;
    logic        out_free;
    logic        finish;
    logic        wr_en;
    logic        in_sec;
    logic [31:0] n_translated;
    logic [2:0]  n_status;
    logic        n_exec;

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign issue        = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign better       = (r_rd_key > r_cmd.addr) && (!r_found || (r_rd_key < r_best_key));
    assign lower        = !r_low_valid || (r_rd_key < r_low_key);
    assign out_free     = !r_o_valid || i_ready;
    assign finish       = (r_state == S_DONE) && out_free;
    assign in_sec       = r_found && (r_cmd.addr >= r_best_start);

    assign o_valid      = r_o_valid;
    assign o_translated = r_o_translated;
    assign o_status     = r_o_status;
    assign o_executable = r_o_exec;

    // result of the finished scan
    always_comb begin
        n_translated = 32'd0;
        n_status     = ST_IN_SECTION;
        n_exec       = 1'b0;
        wr_en        = 1'b0;
        case (r_cmd.mode)
            MODE_CLEAR: begin
                n_status = ST_IN_SECTION;
            end
            MODE_ADD: begin
                if (r_dup) begin
                    n_status = ST_DUPLICATE;
                end else if (r_count >= CW'(MAX_SECTIONS)) begin
                    n_status = ST_TABLE_FULL;
                end else begin
                    wr_en = finish;
                end
            end
            MODE_LOOKUP: begin
                n_exec = in_sec && r_best_exec;
                if (!r_cmd.en) begin
                    n_status     = ST_PASSTHROUGH;
                    n_translated = r_cmd.addr;
                end else if (!r_found) begin
                    n_status = ST_INVALID;
                end else if (in_sec) begin
                    n_status     = ST_IN_SECTION;
                    n_translated = r_best_raw + (r_cmd.addr - r_best_start);
                end else if (r_low_start > r_cmd.addr) begin
                    n_status     = ST_BELOW_FIRST;
                    n_translated = r_cmd.addr;
                end else begin
                    n_status = ST_INVALID;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[r_count[IW-1:0]]   <= r_cmd.key;
            mem_start[r_count[IW-1:0]] <= r_cmd.start;
            mem_raw[r_count[IW-1:0]]   <= r_cmd.raw;
            mem_exec[r_count[IW-1:0]]  <= r_cmd.exec;
        end
        r_rd_key   <= mem_key[r_rd_idx[IW-1:0]];
        r_rd_start <= mem_start[r_rd_idx[IW-1:0]];
        r_rd_raw   <= mem_raw[r_rd_idx[IW-1:0]];
        r_rd_exec  <= mem_exec[r_rd_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (finish) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_idx <= '0;
                    if (!i_empty) begin
                        if (i_cmd.mode == MODE_ADD || i_cmd.mode == MODE_LOOKUP) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end else if (!r_rd_vld) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state   <= S_IDLE;
                        if (r_cmd.mode == MODE_CLEAR) begin
                            r_count <= '0;
                        end else if (wr_en) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // scan trackers and result word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd       <= i_cmd;
            r_found     <= 1'b0;
            r_low_valid <= 1'b0;
            r_dup       <= 1'b0;
        end else if (r_rd_vld) begin
            if (better) begin
                r_found      <= 1'b1;
                r_best_key   <= r_rd_key;
                r_best_start <= r_rd_start;
                r_best_raw   <= r_rd_raw;
                r_best_exec  <= r_rd_exec;
            end
            if (lower) begin
                r_low_valid <= 1'b1;
                r_low_key   <= r_rd_key;
                r_low_start <= r_rd_start;
            end
            if (r_rd_key == r_cmd.key) begin
                r_dup <= 1'b1;
            end
        end
        if (finish) begin
            r_o_translated <= n_translated;
            r_o_status     <= n_status;
            r_o_exec       <= n_exec;
        end
    end

endmodule
